[hdl/ops_pkg.sv]
// ----------------------------------------------------------------------------
// Odd-only prime sieve package
// Shared widths, command codes, microcode word layout, control program and
// the table of known prime counts used by the sieve sequencer.
// ----------------------------------------------------------------------------
package ops_pkg;

  localparam int LIMIT_W       = 17;
  localparam int SLOT_W        = 16;
  localparam int COUNT_W       = 17;
  localparam int SLOTS_DEFAULT = 65536;
  localparam int PC_W          = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

  // command codes
  localparam logic CMD_RUN   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic [PC_W-1:0] pc_t;

  // datapath action selected by the current control word
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_CLEAR,
    ACT_J_ONE,
    ACT_READ_J,
    ACT_SQUARE,
    ACT_S_INIT,
    ACT_MARK,
    ACT_J_INC,
    ACT_COUNT_INIT,
    ACT_COUNT_ACC,
    ACT_RUN_DONE,
    ACT_READ_Q,
    ACT_QUERY_DONE
  } act_e;

  // jump condition of the current control word
  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_START,
    COND_QUERY,
    COND_CLR_MORE,
    COND_J_DONE,
    COND_MARKED,
    COND_SQ_HIGH,
    COND_MARK_MORE
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    pc_t   target;
  } uop_t;

  // program labels
  localparam pc_t PC_IDLE     = pc_t'(0);
  localparam pc_t PC_DISPATCH = pc_t'(1);
  localparam pc_t PC_CLEAR    = pc_t'(2);
  localparam pc_t PC_JINIT    = pc_t'(3);
  localparam pc_t PC_SREAD    = pc_t'(4);
  localparam pc_t PC_SQUARE   = pc_t'(5);
  localparam pc_t PC_SSTART   = pc_t'(6);
  localparam pc_t PC_MARK     = pc_t'(7);
  localparam pc_t PC_NEXTJ    = pc_t'(8);
  localparam pc_t PC_CINIT    = pc_t'(9);
  localparam pc_t PC_CREAD    = pc_t'(10);
  localparam pc_t PC_CACC     = pc_t'(11);
  localparam pc_t PC_RDONE    = pc_t'(12);
  localparam pc_t PC_QREAD    = pc_t'(13);
  localparam pc_t PC_QDONE    = pc_t'(14);

  // control store: one word per step, jump to target when cond holds
  function automatic uop_t microcode(pc_t pc);
    uop_t w;
    w = '{act: ACT_NONE, cond: COND_ALWAYS, target: PC_IDLE};
    unique case (pc)
      PC_IDLE:     w = '{act: ACT_ACCEPT,     cond: COND_NO_START,  target: PC_IDLE};
      PC_DISPATCH: w = '{act: ACT_NONE,       cond: COND_QUERY,     target: PC_QREAD};
      PC_CLEAR:    w = '{act: ACT_CLEAR,      cond: COND_CLR_MORE,  target: PC_CLEAR};
      PC_JINIT:    w = '{act: ACT_J_ONE,      cond: COND_NEVER,     target: PC_IDLE};
      PC_SREAD:    w = '{act: ACT_READ_J,     cond: COND_J_DONE,    target: PC_CINIT};
      PC_SQUARE:   w = '{act: ACT_SQUARE,     cond: COND_MARKED,    target: PC_NEXTJ};
      PC_SSTART:   w = '{act: ACT_S_INIT,     cond: COND_SQ_HIGH,   target: PC_CINIT};
      PC_MARK:     w = '{act: ACT_MARK,       cond: COND_MARK_MORE, target: PC_MARK};
      PC_NEXTJ:    w = '{act: ACT_J_INC,      cond: COND_ALWAYS,    target: PC_SREAD};
      PC_CINIT:    w = '{act: ACT_COUNT_INIT, cond: COND_NEVER,     target: PC_IDLE};
      PC_CREAD:    w = '{act: ACT_READ_J,     cond: COND_J_DONE,    target: PC_RDONE};
      PC_CACC:     w = '{act: ACT_COUNT_ACC,  cond: COND_ALWAYS,    target: PC_CREAD};
      PC_RDONE:    w = '{act: ACT_RUN_DONE,   cond: COND_ALWAYS,    target: PC_IDLE};
      PC_QREAD:    w = '{act: ACT_READ_Q,     cond: COND_NEVER,     target: PC_IDLE};
      PC_QDONE:    w = '{act: ACT_QUERY_DONE, cond: COND_ALWAYS,    target: PC_IDLE};
      default:     w = '{act: ACT_NONE,       cond: COND_ALWAYS,    target: PC_IDLE};
    endcase
    return w;
  endfunction

  // known prime counts; zero where the limit has no entry
  function automatic logic [COUNT_W-1:0] known_count(logic [LIMIT_W-1:0] limit);
    logic [COUNT_W-1:0] key;
    key = '0;
    case (limit)
      LIMIT_W'(10):     key = COUNT_W'(4);
      LIMIT_W'(100):    key = COUNT_W'(25);
      LIMIT_W'(1000):   key = COUNT_W'(168);
      LIMIT_W'(10000):  key = COUNT_W'(1229);
      LIMIT_W'(100000): key = COUNT_W'(9592);
      default:          key = '0;
    endcase
    return key;
  endfunction

endpackage

[hdl/ops_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ops_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/odd_only_prime_sieve.sv]
// ----------------------------------------------------------------------------
// Odd-only prime sieve
// Sieve of Eratosthenes over a bitmap of odd numbers, run by a microcoded
// sequencer, with a slot query command.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at a clock edge with start high
//   and busy low; command_i 0 runs the sieve up to the limit register,
//   command_i 1 queries slot_i (odd number 2*slot+1).
//   Result channel: done_o is high for exactly one cycle with prime_count_o,
//   count_matches_o and prime_value_o valid; the receiver cannot stall it.
//   Config: limit_we_i writes limit_i; assert it only while busy is low (not enforced).
// Sequence:
//   A query reads the bit of its slot, then answers.
//   A run with n = min(limit/2, SLOTS) slots clears the map, then reads
//   each factor slot in turn and, for every unmarked one, squares its
//   factor and marks its multiples from the square on, until a square
//   reaches the limit; then it counts the unmarked slots. The single bitmap
//   RAM port pair and the step-per-cycle control store set the pace.
// Reset:
//   The limit returns to 100 and no run is on record, so every query other
//   than slot zero answers 0 until a run finishes. The bitmap is not swept
//   at reset; each run clears the slots it uses.
// ----------------------------------------------------------------------------
module odd_only_prime_sieve
  import ops_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 command_i,
  input  logic [SLOT_W-1:0]    slot_i,
  input  logic                 limit_we_i,
  input  logic [LIMIT_W-1:0]   limit_i,
  output logic                 done_o,
  output logic [COUNT_W-1:0]   prime_count_o,
  output logic                 count_matches_o,
  output logic [LIMIT_W-1:0]   prime_value_o
);

  localparam int AW   = $clog2(SLOTS);
  localparam int SW   = LIMIT_W + 1;
  localparam int SQ_W = 2 * LIMIT_W;

  pc_t                 pc_q;
  uop_t                uop;
  logic                jump;
  logic                cmd_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [LIMIT_W-1:0]  limit_q;
  logic [LIMIT_W-1:0]  run_slots_q;
  logic [LIMIT_W-1:0]  n_q;
  logic [LIMIT_W-1:0]  j_q;
  logic [SW-1:0]       s_q;
  logic [SQ_W-1:0]     sq_q;
  logic [COUNT_W-1:0]  count_q;
  logic [LIMIT_W-1:0]  half_limit;
  logic [LIMIT_W-1:0]  factor;
  logic [SW-1:0]       s_next;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic                ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic                ram_rdata;
  logic                done_q;
  logic [COUNT_W-1:0]  prime_count_q;
  logic                count_matches_q;
  logic [LIMIT_W-1:0]  prime_value_q;

  // fetch the control word
  assign uop  = microcode(pc_q);
  assign busy = (pc_q != PC_IDLE);

  // odd factor of slot j, next multiple and half the limit
  assign factor     = {j_q[LIMIT_W-2:0], 1'b1};
  assign s_next     = s_q + SW'(factor);
  assign half_limit = {1'b0, limit_q[LIMIT_W-1:1]};

  // evaluate the jump condition
  always_comb begin
    unique case (uop.cond)
      COND_NEVER:     jump = 1'b0;
      COND_ALWAYS:    jump = 1'b1;
      COND_NO_START:  jump = !start;
      COND_QUERY:     jump = (cmd_q == CMD_QUERY);
      COND_CLR_MORE:  jump = (SW'(j_q) + SW'(1)) < SW'(n_q);
      COND_J_DONE:    jump = (j_q >= n_q);
      COND_MARKED:    jump = ram_rdata;
      COND_SQ_HIGH:   jump = (sq_q >= SQ_W'(limit_q));
      COND_MARK_MORE: jump = (s_next < SW'(n_q));
      default:        jump = 1'b0;
    endcase
  end

  // drive the bitmap ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(j_q);
    ram_wdata = 1'b0;
    case (uop.act)
      ACT_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(j_q);
        ram_wdata = (j_q == '0);
      end
      ACT_MARK: begin
        ram_we    = (s_q < SW'(n_q));
        ram_waddr = AW'(s_q);
        ram_wdata = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign ram_raddr = (uop.act == ACT_READ_Q) ? AW'(slot_q) : AW'(j_q);

  ops_ram #(
    .WIDTH (1),
    .DEPTH (SLOTS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // advance the step counter, hold config and run record, pulse done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_IDLE;
      limit_q     <= LIMIT_RESET;
      run_slots_q <= '0;
      done_q      <= 1'b0;
    end else begin
      pc_q   <= jump ? uop.target : pc_t'(pc_q + pc_t'(1));
      done_q <= (uop.act == ACT_RUN_DONE) || (uop.act == ACT_QUERY_DONE);
      if (limit_we_i) begin
        limit_q <= limit_i;
      end
      if (uop.act == ACT_RUN_DONE) begin
        run_slots_q <= n_q;
      end
    end
  end

  // datapath actions
  always_ff @(posedge clk_i) begin
    case (uop.act)
      ACT_ACCEPT: begin
        cmd_q  <= command_i;
        slot_q <= slot_i;
        j_q    <= '0;
        if (SLOTS < int'(half_limit)) begin
          n_q <= LIMIT_W'(SLOTS);
        end else begin
          n_q <= half_limit;
        end
      end
      ACT_CLEAR:   j_q  <= j_q + LIMIT_W'(1);
      ACT_J_ONE:   j_q  <= LIMIT_W'(1);
      ACT_SQUARE:  sq_q <= SQ_W'(factor) * SQ_W'(factor);
      ACT_S_INIT:  s_q  <= SW'((sq_q - SQ_W'(1)) >> 1);
      ACT_MARK:    s_q  <= s_next;
      ACT_J_INC:   j_q  <= j_q + LIMIT_W'(1);
      ACT_COUNT_INIT: begin
        j_q     <= LIMIT_W'(1);
        count_q <= COUNT_W'(1);
      end
      ACT_COUNT_ACC: begin
        j_q     <= j_q + LIMIT_W'(1);
        count_q <= count_q + COUNT_W'(!ram_rdata);
      end
      ACT_RUN_DONE: begin
        prime_count_q   <= count_q;
        count_matches_q <= (count_q == known_count(limit_q));
        prime_value_q   <= '0;
      end
      ACT_QUERY_DONE: begin
        prime_count_q   <= '0;
        count_matches_q <= 1'b0;
        if (slot_q == '0) begin
          prime_value_q <= LIMIT_W'(2);
        end else if ((LIMIT_W'(slot_q) < run_slots_q) && !ram_rdata) begin
          prime_value_q <= {slot_q, 1'b1};
        end else begin
          prime_value_q <= '0;
        end
      end
      default: begin
        cmd_q <= cmd_q;
      end
    endcase
  end

  assign done_o          = done_q;
  assign prime_count_o   = prime_count_q;
  assign count_matches_o = count_matches_q;
  assign prime_value_o   = prime_value_q;

  // a result comes out only as the sequencer returns to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while sequencer busy");

  // a taken transaction makes the sequencer busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("transaction taken but sequencer stayed idle");

  // a result carries either a run count or a query value
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (prime_count_o == '0 || prime_value_o == '0))
    else $error("result mixes run and query fields");

  // the step counter stays inside the program
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= PC_QDONE)
    else $error("step counter outside control store");

endmodule
